// ===== rtl/ca3_pkg.sv =====
// Shared constants, codes and types of the 3-D life cellular automaton.
package ca3_pkg;

  localparam int MAX_X = 32;
  localparam int MAX_Y = 32;
  localparam int MAX_Z = 32;

  localparam int COORD_W = 5;
  localparam int Y_W     = $clog2(MAX_Y);
  localparam int Z_W     = $clog2(MAX_Z);
  localparam int X_W     = $clog2(MAX_X);
  localparam int ROW_W   = Y_W + Z_W;
  localparam int ROWS    = MAX_Y * MAX_Z;

  localparam int SIZE_W = 6;
  localparam int RULE_W = 5;
  localparam int CNT_W  = 5;
  localparam int FUNC_W = 2;
  localparam int REG_W  = 3;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd2;

  localparam logic [REG_W-1:0] REG_SIZE_X       = 3'd0;
  localparam logic [REG_W-1:0] REG_SIZE_Y       = 3'd1;
  localparam logic [REG_W-1:0] REG_SIZE_Z       = 3'd2;
  localparam logic [REG_W-1:0] REG_SURVIVE_LOW  = 3'd3;
  localparam logic [REG_W-1:0] REG_SURVIVE_HIGH = 3'd4;
  localparam logic [REG_W-1:0] REG_BIRTH_LOW    = 3'd5;
  localparam logic [REG_W-1:0] REG_BIRTH_HIGH   = 3'd6;
  localparam logic [REG_W-1:0] REG_WRAP_EDGES   = 3'd7;

  // Neighbor offset codes along one axis: -1, 0, +1.
  localparam logic [1:0] NB_LO  = 2'd0;
  localparam logic [1:0] NB_MID = 2'd1;
  localparam logic [1:0] NB_HI  = 2'd2;

  typedef struct packed {
    logic clr;
    logic acc;
    logic center;
  } row_ctl_t;

  typedef struct packed {
    logic [SIZE_W-1:0] nx;
    logic              wrap;
    logic [RULE_W-1:0] survive_low;
    logic [RULE_W-1:0] survive_high;
    logic [RULE_W-1:0] birth_low;
    logic [RULE_W-1:0] birth_high;
  } rule_cfg_t;

endpackage

// ===== rtl/ca3_row_eval.sv =====
// Row evaluator: accumulates neighbor counts for one row of cells and forms its next state.
module ca3_row_eval (
  input  logic                        clk,
  input  ca3_pkg::row_ctl_t           ctl,
  input  logic [ca3_pkg::MAX_X-1:0]   row,
  input  ca3_pkg::rule_cfg_t          cfg,
  output logic [ca3_pkg::MAX_X-1:0]   next_row,
  output logic                        changed
);

  logic [ca3_pkg::CNT_W-1:0] cnt [ca3_pkg::MAX_X];
  logic [ca3_pkg::CNT_W-1:0] cnt_next [ca3_pkg::MAX_X];
  logic [ca3_pkg::MAX_X-1:0] center_row;
  logic [ca3_pkg::MAX_X-1:0] left;
  logic [ca3_pkg::MAX_X-1:0] right;
  logic [ca3_pkg::MAX_X-1:0] edge_hi;
  logic [ca3_pkg::X_W-1:0]   nx_last;

  // Bit x of left is the cell at x-1, bit x of right the cell at x+1.
  always_comb begin
    nx_last = ca3_pkg::X_W'(cfg.nx - 1'b1);
    edge_hi = '0;
    edge_hi[nx_last] = cfg.wrap & row[0];
    left  = {row[ca3_pkg::MAX_X-2:0], cfg.wrap & row[nx_last]};
    right = {1'b0, row[ca3_pkg::MAX_X-1:1]} | edge_hi;
    for (int x = 0; x < ca3_pkg::MAX_X; x++) begin
      cnt_next[x] = cnt[x] + ca3_pkg::CNT_W'(left[x]) + ca3_pkg::CNT_W'(right[x])
                  + ca3_pkg::CNT_W'(row[x] & ~ctl.center);
    end
  end

  always_ff @(posedge clk) begin
    for (int x = 0; x < ca3_pkg::MAX_X; x++) begin
      if (ctl.clr) begin
        cnt[x] <= '0;
      end else if (ctl.acc) begin
        cnt[x] <= cnt_next[x];
      end
    end
    if (ctl.acc && ctl.center) begin
      center_row <= row;
    end
  end

  always_comb begin
    for (int x = 0; x < ca3_pkg::MAX_X; x++) begin
      next_row[x] = (ca3_pkg::SIZE_W'(x) < cfg.nx) &&
                    ((center_row[x] && cnt[x] >= cfg.survive_low &&
                      cnt[x] <= cfg.survive_high) ||
                     (cnt[x] >= cfg.birth_low && cnt[x] <= cfg.birth_high));
    end
    changed = |(next_row ^ center_row);
  end

endmodule

// ===== rtl/cellular_automaton_3d_step_top.sv =====
// Top level of the 3-D life cellular automaton engine.
// The grid lives in two 1024 x 32 row memories (one row per y,z pair, one bit per x cell),
// current and next, swapped after each generation. A cell write or read goes through one
// memory read, one read-modify-write or pick, and one load of the result register before
// the next word is taken. A generation visits every row in use, size_y * size_z rows:
// for each, the nine neighbor rows come one per cycle through the single read port, then
// the new row is written. After reset, and after every write to a size register, both
// grids are cleared, all 1024 rows, and no word is accepted meanwhile. A result word
// waits in an output register, so the next word is accepted while it is pending.
module cellular_automaton_3d_step_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,   // func[1:0], cell_x[6:2], cell_y[11:7],
                                                 // cell_z[16:12], write_value[17], zero pad
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // read_value[0], settled[1], zero pad
  input  logic                        cfg_we,
  input  logic [ca3_pkg::REG_W-1:0]   cfg_addr,
  input  logic [ca3_pkg::SIZE_W-1:0]  cfg_data
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CELL   = 3'd2;
  localparam logic [2:0] ST_GEN    = 3'd3;
  localparam logic [2:0] ST_GEN_WR = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  localparam logic [3:0] PH_LAST = 4'd9;

  logic [2:0] state;
  logic       cur_a;

  logic [ca3_pkg::SIZE_W-1:0] size_x, size_y, size_z;
  logic [ca3_pkg::RULE_W-1:0] survive_low, survive_high, birth_low, birth_high;
  logic                       wrap_edges;
  logic [ca3_pkg::SIZE_W-1:0] nx, ny, nz;

  logic [ca3_pkg::MAX_X-1:0] mem_a [ca3_pkg::ROWS];
  logic [ca3_pkg::MAX_X-1:0] mem_b [ca3_pkg::ROWS];
  logic [ca3_pkg::MAX_X-1:0] a_q, b_q, cur_q;
  logic [ca3_pkg::ROW_W-1:0] rd_addr, wr_addr, clr_addr;
  logic                      wr_a_en, wr_b_en;
  logic [ca3_pkg::MAX_X-1:0] wr_data;

  logic [ca3_pkg::FUNC_W-1:0]  in_func;
  logic [ca3_pkg::COORD_W-1:0] in_x, in_y, in_z;
  logic                        in_wv, in_inside;

  logic [ca3_pkg::FUNC_W-1:0]  op;
  logic [ca3_pkg::COORD_W-1:0] op_x;
  logic                        op_wv, op_in;
  logic [ca3_pkg::ROW_W-1:0]   op_row;

  logic [ca3_pkg::COORD_W-1:0] gy, gz;
  logic [3:0]                  ph;
  logic [1:0]                  iy, iz;
  logic                        same;
  logic                        pend_acc, pend_ok, pend_center;
  logic [ca3_pkg::COORD_W:0]   ny_sel, nz_sel;
  logic [ca3_pkg::ROW_W-1:0]   gen_addr;

  logic res_read, res_settled, out_read, out_settled;
  logic size_we, out_load;

  ca3_pkg::row_ctl_t         ctl;
  ca3_pkg::rule_cfg_t        rcfg;
  logic [ca3_pkg::MAX_X-1:0] eval_row, next_row;
  logic                      changed;

  // Neighbor coordinate along one axis; the top bit says whether it lies on the grid.
  function automatic logic [ca3_pkg::COORD_W:0] nb_coord(
    input logic [ca3_pkg::COORD_W-1:0] c,
    input logic [1:0]                  idx,
    input logic [ca3_pkg::SIZE_W-1:0]  n,
    input logic                        wrap
  );
    logic [ca3_pkg::COORD_W-1:0] last;
    logic [ca3_pkg::COORD_W-1:0] v;
    logic                        ok;
    last = ca3_pkg::COORD_W'(n - 1'b1);
    ok = 1'b1;
    v = c;
    case (idx)
      ca3_pkg::NB_LO: begin
        if (c == '0) begin
          v = last;
          ok = wrap;
        end else begin
          v = c - 1'b1;
        end
      end
      ca3_pkg::NB_HI: begin
        if (c == last) begin
          v = '0;
          ok = wrap;
        end else begin
          v = c + 1'b1;
        end
      end
      default: v = c;
    endcase
    return {ok, v};
  endfunction

  assign nx = (size_x > ca3_pkg::SIZE_W'(ca3_pkg::MAX_X)) ? ca3_pkg::SIZE_W'(ca3_pkg::MAX_X) : size_x;
  assign ny = (size_y > ca3_pkg::SIZE_W'(ca3_pkg::MAX_Y)) ? ca3_pkg::SIZE_W'(ca3_pkg::MAX_Y) : size_y;
  assign nz = (size_z > ca3_pkg::SIZE_W'(ca3_pkg::MAX_Z)) ? ca3_pkg::SIZE_W'(ca3_pkg::MAX_Z) : size_z;

  assign in_func = s_tdata[1:0];
  assign in_x    = s_tdata[6:2];
  assign in_y    = s_tdata[11:7];
  assign in_z    = s_tdata[16:12];
  assign in_wv   = s_tdata[17];
  assign in_inside = ({1'b0, in_x} < nx) && ({1'b0, in_y} < ny) && ({1'b0, in_z} < nz);

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {6'b0, out_settled, out_read};
  assign cur_q    = cur_a ? a_q : b_q;

  assign size_we  = cfg_we && (cfg_addr == ca3_pkg::REG_SIZE_X ||
                               cfg_addr == ca3_pkg::REG_SIZE_Y ||
                               cfg_addr == ca3_pkg::REG_SIZE_Z);
  assign out_load = (state == ST_DONE) && !size_we && (!m_tvalid || m_tready);

  assign ny_sel   = nb_coord(gy, iy, ny, wrap_edges);
  assign nz_sel   = nb_coord(gz, iz, nz, wrap_edges);
  assign gen_addr = {ca3_pkg::Z_W'(nz_sel[ca3_pkg::COORD_W-1:0]),
                     ca3_pkg::Y_W'(ny_sel[ca3_pkg::COORD_W-1:0])};

  always_comb begin
    case (state)
      ST_IDLE: rd_addr = {ca3_pkg::Z_W'(in_z), ca3_pkg::Y_W'(in_y)};
      ST_GEN:  rd_addr = gen_addr;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_a_en = 1'b0;
    wr_b_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state)
      ST_CLEAR: begin
        wr_a_en = 1'b1;
        wr_b_en = 1'b1;
        wr_addr = clr_addr;
      end
      ST_CELL: begin
        wr_addr = op_row;
        wr_data = cur_q;
        wr_data[op_x] = op_wv;
        if (op == ca3_pkg::FUNC_WRITE && op_in) begin
          wr_a_en = cur_a;
          wr_b_en = ~cur_a;
        end
      end
      ST_GEN_WR: begin
        wr_addr = {ca3_pkg::Z_W'(gz), ca3_pkg::Y_W'(gy)};
        wr_data = next_row;
        wr_a_en = ~cur_a;
        wr_b_en = cur_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    a_q <= mem_a[rd_addr];
    b_q <= mem_b[rd_addr];
    if (wr_a_en) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (wr_b_en) begin
      mem_b[wr_addr] <= wr_data;
    end
  end

  assign ctl.clr    = (state == ST_GEN) && (ph == '0);
  assign ctl.acc    = pend_acc;
  assign ctl.center = pend_center;
  assign eval_row   = pend_ok ? cur_q : '0;

  assign rcfg.nx           = nx;
  assign rcfg.wrap         = wrap_edges;
  assign rcfg.survive_low  = survive_low;
  assign rcfg.survive_high = survive_high;
  assign rcfg.birth_low    = birth_low;
  assign rcfg.birth_high   = birth_high;

  ca3_row_eval u_eval (
    .clk      (clk),
    .ctl      (ctl),
    .row      (eval_row),
    .cfg      (rcfg),
    .next_row (next_row),
    .changed  (changed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      cur_a        <= 1'b1;
      size_x       <= 6'd30;
      size_y       <= 6'd30;
      size_z       <= 6'd30;
      survive_low  <= 5'd5;
      survive_high <= 5'd7;
      birth_low    <= 5'd6;
      birth_high   <= 5'd6;
      wrap_edges   <= 1'b0;
      m_tvalid     <= 1'b0;
      pend_acc     <= 1'b0;
    end else begin
      pend_acc <= 1'b0;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // A new grid size starts from an empty grid.
      if (size_we) begin
        state    <= ST_CLEAR;
        clr_addr <= '0;
      end else begin
        case (state)
          ST_CLEAR: begin
            clr_addr <= clr_addr + 1'b1;
            if (clr_addr == ca3_pkg::ROW_W'(ca3_pkg::ROWS - 1)) begin
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (s_tvalid) begin
              if (in_func == ca3_pkg::FUNC_STEP) begin
                if (nx == '0 || ny == '0 || nz == '0) begin
                  cur_a       <= ~cur_a;
                  res_read    <= 1'b0;
                  res_settled <= 1'b1;
                  state       <= ST_DONE;
                end else begin
                  gy    <= '0;
                  gz    <= '0;
                  ph    <= '0;
                  iy    <= ca3_pkg::NB_LO;
                  iz    <= ca3_pkg::NB_LO;
                  same  <= 1'b1;
                  state <= ST_GEN;
                end
              end else begin
                op     <= in_func;
                op_x   <= in_x;
                op_wv  <= in_wv;
                op_in  <= in_inside;
                op_row <= {ca3_pkg::Z_W'(in_z), ca3_pkg::Y_W'(in_y)};
                state  <= ST_CELL;
              end
            end
          end
          ST_CELL: begin
            res_read    <= (op == ca3_pkg::FUNC_READ) && op_in && cur_q[op_x];
            res_settled <= 1'b0;
            state       <= ST_DONE;
          end
          ST_GEN: begin
            if (ph == PH_LAST) begin
              state <= ST_GEN_WR;
            end else begin
              pend_acc    <= 1'b1;
              pend_ok     <= ny_sel[ca3_pkg::COORD_W] & nz_sel[ca3_pkg::COORD_W];
              pend_center <= (iy == ca3_pkg::NB_MID) && (iz == ca3_pkg::NB_MID);
              ph          <= ph + 1'b1;
              if (iy == ca3_pkg::NB_HI) begin
                iy <= ca3_pkg::NB_LO;
                iz <= iz + 1'b1;
              end else begin
                iy <= iy + 1'b1;
              end
            end
          end
          ST_GEN_WR: begin
            same  <= same & ~changed;
            ph    <= '0;
            iy    <= ca3_pkg::NB_LO;
            iz    <= ca3_pkg::NB_LO;
            state <= ST_GEN;
            if (gy == ca3_pkg::COORD_W'(ny - 1'b1)) begin
              gy <= '0;
              if (gz == ca3_pkg::COORD_W'(nz - 1'b1)) begin
                cur_a       <= ~cur_a;
                res_read    <= 1'b0;
                res_settled <= same & ~changed;
                state       <= ST_DONE;
              end else begin
                gz <= gz + 1'b1;
              end
            end else begin
              gy <= gy + 1'b1;
            end
          end
          ST_DONE: begin
            if (out_load) begin
              out_read    <= res_read;
              out_settled <= res_settled;
              state       <= ST_IDLE;
            end
          end
          default: state <= ST_IDLE;
        endcase
      end

      if (cfg_we) begin
        case (cfg_addr)
          ca3_pkg::REG_SIZE_X:       size_x       <= cfg_data;
          ca3_pkg::REG_SIZE_Y:       size_y       <= cfg_data;
          ca3_pkg::REG_SIZE_Z:       size_z       <= cfg_data;
          ca3_pkg::REG_SURVIVE_LOW:  survive_low  <= cfg_data[ca3_pkg::RULE_W-1:0];
          ca3_pkg::REG_SURVIVE_HIGH: survive_high <= cfg_data[ca3_pkg::RULE_W-1:0];
          ca3_pkg::REG_BIRTH_LOW:    birth_low    <= cfg_data[ca3_pkg::RULE_W-1:0];
          ca3_pkg::REG_BIRTH_HIGH:   birth_high   <= cfg_data[ca3_pkg::RULE_W-1:0];
          ca3_pkg::REG_WRAP_EDGES:   wrap_edges   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/ca3_checker.sv =====
// Port-level checks of the 3-D life engine, bound to its top level.
module ca3_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  // The grid is being cleared right after reset.
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready right after reset");

  // The engine is never ready in the cycle after it takes a word.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready in the cycle after an accepted word");

  // A read result and a settled flag never come from the same word.
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("read value and settled both set");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:2] == 6'b0))
    else $error("result pad bits not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind cellular_automaton_3d_step_top ca3_checker u_ca3_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
